// ===== rtl/pvom_pkg.sv =====
// shared constants for the polyphonic voice oscillator mixer
// no dependencies
package pvom_pkg;

    localparam int DEFAULT_VOICES     = 64;
    localparam int DEFAULT_PHASE_BITS = 24;

    localparam int KEY_W    = 11;
    localparam int STEP_W   = 24;
    localparam int LEVEL_W  = 8;
    localparam int CMD_W    = 2;
    localparam int SHAPE_W  = 2;
    localparam int SAMPLE_W = 8;

    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE  = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SAW     = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_REV_SAW = 2'd2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

endpackage

// ===== rtl/polyphonic_voice_oscillator_mixer_unit.sv =====
// channel | signals                                          | direction
// input   | i_in_valid o_in_stall i_cmd i_voice_key          | into block
//         | i_phase_step i_level                             |
// output  | o_out_valid i_out_stall o_sample                 | out of block
// config  | i_cfg_we i_cfg_wdata                             | into block
//
// every note on, note off or tick rotates the whole voice ring once, and a note
// off rotates it a second time when the key is found; after its transfer the
// input stays stalled for them, and for a tick also for its flush and output wait
// the ring rotation, one slot per cycle through a shared multiplier, sets the rate
// reset (synchronous, active low) empties the voice table and sets reverse sawtooth
// the input is stalled while a command is in work; a held result delays only a tick
//
// top level; depends on pvom_pkg and pvom_cell
module polyphonic_voice_oscillator_mixer_unit #(
    parameter int VOICES     = pvom_pkg::DEFAULT_VOICES,
    parameter int PHASE_BITS = pvom_pkg::DEFAULT_PHASE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pvom_pkg::CMD_W-1:0]      i_cmd,
    input  logic [pvom_pkg::KEY_W-1:0]      i_voice_key,
    input  logic [pvom_pkg::STEP_W-1:0]     i_phase_step,
    input  logic [pvom_pkg::LEVEL_W-1:0]    i_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pvom_pkg::SAMPLE_W-1:0]   o_sample,
    input  logic                            i_cfg_we,
    input  logic [pvom_pkg::SHAPE_W-1:0]    i_cfg_wdata
);

    localparam int CW = $clog2(VOICES + 1);
    localparam int AW = PHASE_BITS + 1 + pvom_pkg::LEVEL_W + CW;
    localparam int PW = PHASE_BITS + 1 + pvom_pkg::LEVEL_W;
    localparam logic [PHASE_BITS:0] PH_ONE  = (PHASE_BITS + 1)'(1) << PHASE_BITS;
    localparam logic [PHASE_BITS:0] PH_HALF = (PHASE_BITS + 1)'(1) << (PHASE_BITS - 1);
    localparam logic [CW-1:0] LAST_J = CW'(VOICES - 1);
    localparam logic [CW-1:0] VMAX   = CW'(VOICES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ON    = 3'd1;
    localparam logic [2:0] ST_OFF1  = 3'd2;
    localparam logic [2:0] ST_OFF2  = 3'd3;
    localparam logic [2:0] ST_TICK  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                    r_state, n_state;
    logic [CW-1:0]                 r_j, n_j;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_slot, n_slot;
    logic                          r_found, n_found;
    logic                          r_added, n_added;
    logic [pvom_pkg::SHAPE_W-1:0]  r_shape;
    logic [pvom_pkg::KEY_W-1:0]    r_key;
    logic [PHASE_BITS-1:0]         r_step;
    logic [pvom_pkg::LEVEL_W-1:0]  r_level;
    logic [pvom_pkg::KEY_W-1:0]    r_last_key;
    logic [PHASE_BITS-1:0]         r_last_step;
    logic [pvom_pkg::LEVEL_W-1:0]  r_last_level;
    logic [PHASE_BITS:0]           r_last_phase;
    logic                          r_s1_vld, r_s2_vld;
    logic [PHASE_BITS:0]           r_s1_phase;
    logic [pvom_pkg::LEVEL_W-1:0]  r_s1_level;
    logic [PW-1:0]                 r_prod;
    logic [AW-1:0]                 r_acc;
    logic                          r_out_valid;
    logic [pvom_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_flush;

    logic [pvom_pkg::KEY_W-1:0]    w_key   [VOICES+1];
    logic [PHASE_BITS-1:0]         w_step  [VOICES+1];
    logic [pvom_pkg::LEVEL_W-1:0]  w_level [VOICES+1];
    logic [PHASE_BITS:0]           w_phase [VOICES+1];

    logic [pvom_pkg::KEY_W-1:0]    tail_key;
    logic [PHASE_BITS-1:0]         tail_step;
    logic [pvom_pkg::LEVEL_W-1:0]  tail_level;
    logic [PHASE_BITS:0]           tail_phase;

    logic        shift;
    logic        in_accept;
    logic        head_act;
    logic        head_match;
    logic [31:0] step_ext;
    logic [PHASE_BITS:0] ph_sum, ph_new, wave;
    logic [AW-PHASE_BITS-1:0] whole;
    logic        out_free;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign shift      = (r_state == ST_ON) || (r_state == ST_OFF1) ||
                        (r_state == ST_OFF2) || (r_state == ST_TICK);
    assign step_ext   = {{(32 - pvom_pkg::STEP_W){1'b0}}, i_phase_step};
    assign head_act   = (r_j < r_count);
    assign head_match = head_act && (w_key[0] == r_key);
    assign out_free   = !r_out_valid || !i_out_stall;

    genvar gi;
    generate
        for (gi = 0; gi < VOICES; gi++) begin : g_cell
            pvom_cell #(.PHASE_BITS(PHASE_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_key   (w_key[gi+1]),
                .i_step  (w_step[gi+1]),
                .i_level (w_level[gi+1]),
                .i_phase (w_phase[gi+1]),
                .o_key   (w_key[gi]),
                .o_step  (w_step[gi]),
                .o_level (w_level[gi]),
                .o_phase (w_phase[gi])
            );
        end
    endgenerate

    // phase advance of the head voice
    always_comb begin
        ph_sum = w_phase[0] + {1'b0, w_step[0]};
        ph_new = (ph_sum > PH_ONE) ? ph_sum - PH_ONE : ph_sum;
    end

    // tail of the ring: head wraps around, possibly replaced or its phase advanced
    always_comb begin
        tail_key   = w_key[0];
        tail_step  = w_step[0];
        tail_level = w_level[0];
        tail_phase = w_phase[0];
        case (r_state)
            ST_ON: begin
                if (r_j == r_count && !r_found && r_count < VMAX && r_step != '0) begin
                    tail_key   = r_key;
                    tail_step  = r_step;
                    tail_level = r_level;
                    tail_phase = '0;
                end
            end
            ST_OFF2: begin
                if (r_j == r_slot) begin
                    tail_key   = r_last_key;
                    tail_step  = r_last_step;
                    tail_level = r_last_level;
                    tail_phase = r_last_phase;
                end
            end
            ST_TICK: begin
                if (head_act) begin
                    tail_phase = ph_new;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_key[VOICES]   = tail_key;
    assign w_step[VOICES]  = tail_step;
    assign w_level[VOICES] = tail_level;
    assign w_phase[VOICES] = tail_phase;

    always_comb begin
        case (r_shape)
            pvom_pkg::SHAPE_SQUARE: wave = (r_s1_phase <= PH_HALF) ? PH_ONE : '0;
            pvom_pkg::SHAPE_SAW:    wave = r_s1_phase;
            default:                wave = PH_ONE - r_s1_phase;
        endcase
        whole = r_acc[AW-1:PHASE_BITS];
    end

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_count = r_count;
        n_slot  = r_slot;
        n_found = r_found;
        n_added = r_added;
        case (r_state)
            ST_IDLE: begin
                n_j     = '0;
                n_found = 1'b0;
                n_added = 1'b0;
                if (in_accept) begin
                    case (i_cmd)
                        pvom_pkg::CMD_NOTE_ON:  n_state = ST_ON;
                        pvom_pkg::CMD_NOTE_OFF: n_state = ST_OFF1;
                        pvom_pkg::CMD_TICK:     n_state = ST_TICK;
                        default:                n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ON: begin
                n_j = r_j + 1'b1;
                if (head_match) n_found = 1'b1;
                if (r_j == r_count && !r_found && r_count < VMAX && r_step != '0) begin
                    n_added = 1'b1;
                end
                if (r_j == LAST_J) begin
                    n_j     = '0;
                    n_state = ST_IDLE;
                    if (n_added) n_count = r_count + 1'b1;
                end
            end
            ST_OFF1: begin
                n_j = r_j + 1'b1;
                if (head_match && !r_found) begin
                    n_found = 1'b1;
                    n_slot  = r_j;
                end
                if (r_j == LAST_J) begin
                    n_j     = '0;
                    n_state = n_found ? ST_OFF2 : ST_IDLE;
                end
            end
            ST_OFF2: begin
                n_j = r_j + 1'b1;
                if (r_j == LAST_J) begin
                    n_j     = '0;
                    n_count = r_count - 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                n_j = r_j + 1'b1;
                if (r_j == LAST_J) begin
                    n_j     = '0;
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (r_flush) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_j         <= '0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_added     <= 1'b0;
            r_shape     <= pvom_pkg::SHAPE_REV_SAW;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_flush     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_count  <= n_count;
            r_found  <= n_found;
            r_added  <= n_added;
            if (i_cfg_we) r_shape <= i_cfg_wdata;
            r_s1_vld <= (r_state == ST_TICK) && head_act;
            r_s2_vld <= r_s1_vld;
            r_flush  <= (r_state == ST_FLUSH) && !r_flush;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (in_accept) begin
            r_key   <= i_voice_key;
            r_step  <= step_ext[PHASE_BITS-1:0];
            r_level <= i_level;
        end
        if (r_state == ST_OFF1 && r_j == r_count - 1'b1) begin
            r_last_key   <= w_key[0];
            r_last_step  <= w_step[0];
            r_last_level <= w_level[0];
            r_last_phase <= w_phase[0];
        end
        r_s1_phase <= ph_new;
        r_s1_level <= w_level[0];
        r_prod     <= PW'(r_s1_level) * PW'(wave);
        if (r_state == ST_IDLE) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        if (r_state == ST_DONE && out_free) begin
            r_sample <= (whole >= (AW - PHASE_BITS)'(pvom_pkg::SAMPLE_MAX))
                        ? pvom_pkg::SAMPLE_MAX : whole[pvom_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= VMAX) else $error("voice count beyond table size");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_cmd == pvom_pkg::CMD_TICK |=> r_state == ST_TICK)
        else $error("tick did not start a ring pass");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE && !in_accept |=> $stable(r_count))
        else $error("voice count changed while idle");

    a_result_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside tick completion");

endmodule

// ===== rtl/pvom_cell.sv =====
// one voice slot of the rotating voice ring
// depends on pvom_pkg
module pvom_cell #(
    parameter int PHASE_BITS = pvom_pkg::DEFAULT_PHASE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic [pvom_pkg::KEY_W-1:0]   i_key,
    input  logic [PHASE_BITS-1:0]        i_step,
    input  logic [pvom_pkg::LEVEL_W-1:0] i_level,
    input  logic [PHASE_BITS:0]          i_phase,
    output logic [pvom_pkg::KEY_W-1:0]   o_key,
    output logic [PHASE_BITS-1:0]        o_step,
    output logic [pvom_pkg::LEVEL_W-1:0] o_level,
    output logic [PHASE_BITS:0]          o_phase
);

    logic [pvom_pkg::KEY_W-1:0]   r_key;
    logic [PHASE_BITS-1:0]        r_step;
    logic [pvom_pkg::LEVEL_W-1:0] r_level;
    logic [PHASE_BITS:0]          r_phase;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_key;
            r_step  <= i_step;
            r_level <= i_level;
            r_phase <= i_phase;
        end
    end

    assign o_key   = r_key;
    assign o_step  = r_step;
    assign o_level = r_level;
    assign o_phase = r_phase;

endmodule
